@@ rtl/mdf_pkg.sv @@
// Shared types, constants and register indexes of the mesh duplicate filter.
package mdf_pkg;

  localparam int DEF_ID_DEPTH = 32;

  localparam logic [7:0] EXT_SERVICE_FLOOR = 8'd16;

  localparam logic [2:0] CFG_BCAST_ADDR = 3'd0;
  localparam logic [2:0] CFG_LOCAL_BIT  = 3'd1;
  localparam logic [2:0] CFG_TEXT_SVC   = 3'd2;
  localparam logic [2:0] CFG_CMD_SVC    = 3'd3;
  localparam logic [2:0] CFG_ALIVE_SVC  = 3'd4;
  localparam logic [2:0] CFG_SHOW_HB    = 3'd5;

  localparam logic [31:0] RST_BCAST_ADDR = 32'hFFFF_FFFF;
  localparam logic [2:0]  RST_LOCAL_BIT  = 3'd7;
  localparam logic [7:0]  RST_TEXT_SVC   = 8'd0;
  localparam logic [7:0]  RST_CMD_SVC    = 8'd1;
  localparam logic [7:0]  RST_ALIVE_SVC  = 8'd2;
  localparam logic        RST_SHOW_HB    = 1'b1;

  localparam logic ACT_CHECK  = 1'b0;
  localparam logic ACT_RECORD = 1'b1;

  localparam logic [1:0] CAST_DIRECT = 2'd0;
  localparam logic [1:0] CAST_BCAST  = 2'd1;
  localparam logic [1:0] CAST_LOCAL  = 2'd2;

  localparam logic [2:0] CLS_NONE  = 3'd0;
  localparam logic [2:0] CLS_TEXT  = 3'd1;
  localparam logic [2:0] CLS_CMD   = 3'd2;
  localparam logic [2:0] CLS_ALIVE = 3'd3;
  localparam logic [2:0] CLS_EXT   = 3'd4;

  typedef struct packed {
    logic tok;
    logic hit;
  } mdf_link_t;

endpackage

@@ rtl/mdf_cell.sv @@
// One ID store cell: holds an entry and passes the search token and hit flag on.
module mdf_cell
  import mdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] key,
  input  logic        wr_en,
  input  logic [31:0] wr_data,
  input  mdf_link_t   link_in,
  output mdf_link_t   link_out
);

  logic [31:0] entry_r;
  mdf_link_t   link_r;
  mdf_link_t   link_nxt;

  always_comb begin
    link_nxt.tok = link_in.tok;
    link_nxt.hit = link_in.hit | (link_in.tok & (entry_r == key));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
      link_r  <= '0;
    end else begin
      link_r <= link_nxt;
      if (wr_en) begin
        entry_r <= wr_data;
      end
    end
  end

  assign link_out = link_r;

endmodule

@@ rtl/mesh_duplicate_filter.sv @@
// Top level of the mesh duplicate filter: control, classification and cell chain.
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_ready   | action, packet_id, dest_address, flags, service
//  out_    | output    | out_valid / out_ready | duplicate, forward, cast_kind, handling_class
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A check item sends a search token that walks the chain of ID_DEPTH cells one cell per
// cycle; a record item goes straight from acceptance to the result step.
// One item is in work at a time; the next is accepted once the result is in the
// output register. A stalled output holds the finished item until taken.
// Reset is synchronous: it clears the ID store, pointer and state and loads default settings.
module mesh_duplicate_filter
  import mdf_pkg::*;
#(
  parameter int ID_DEPTH = DEF_ID_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [31:0] in_packet_id,
  input  logic [31:0] in_dest_address,
  input  logic [7:0]  in_packet_flags,
  input  logic [7:0]  in_packet_service,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_duplicate,
  output logic        out_forward,
  output logic [1:0]  out_cast_kind,
  output logic [2:0]  out_handling_class,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int PTR_W = (ID_DEPTH > 1) ? $clog2(ID_DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  state_t      state_r;
  logic [31:0] bcast_addr_r;
  logic [2:0]  local_bit_r;
  logic [7:0]  text_svc_r;
  logic [7:0]  cmd_svc_r;
  logic [7:0]  alive_svc_r;
  logic        show_hb_r;

  logic        action_r;
  logic [31:0] key_r;
  logic [31:0] dest_r;
  logic [7:0]  flags_r;
  logic [7:0]  svc_r;
  logic        hit_r;
  logic        start_r;
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] wp_nxt;

  logic        out_valid_r;
  logic        dup_r;
  logic        fwd_r;
  logic [1:0]  kind_r;
  logic [2:0]  cls_r;

  logic        in_acc;
  logic        slot_free;
  logic        finish;
  logic        store_en;
  logic        bcast;
  logic        local_bc;
  logic        fwd_nxt;
  logic [1:0]  kind_nxt;
  logic [2:0]  cls_nxt;

  logic [ID_DEPTH-1:0] wr_sel;
  mdf_link_t           link [ID_DEPTH+1];

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid & in_ready;
  assign slot_free = ~out_valid_r | out_ready;
  assign finish    = (state_r == S_FIN) & slot_free;
  assign store_en  = finish & ((action_r == ACT_RECORD) | ~hit_r);
  assign wp_nxt    = (wp_r == PTR_W'(ID_DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);

  assign link[0] = '{tok: start_r, hit: 1'b0};

  for (genvar g = 0; g < ID_DEPTH; g++) begin : g_cell
    assign wr_sel[g] = store_en & (wp_nxt == PTR_W'(g));
    mdf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .key      (key_r),
      .wr_en    (wr_sel[g]),
      .wr_data  (key_r),
      .link_in  (link[g]),
      .link_out (link[g+1])
    );
  end

  always_comb begin
    bcast    = (dest_r == bcast_addr_r);
    local_bc = flags_r[local_bit_r];
    fwd_nxt  = bcast & ~local_bc;
    kind_nxt = !bcast ? CAST_DIRECT : (local_bc ? CAST_LOCAL : CAST_BCAST);
    if (svc_r == text_svc_r) begin
      cls_nxt = CLS_TEXT;
    end else if (svc_r == cmd_svc_r) begin
      cls_nxt = CLS_CMD;
    end else if ((svc_r == alive_svc_r) && show_hb_r) begin
      cls_nxt = CLS_ALIVE;
    end else if (svc_r > EXT_SERVICE_FLOOR) begin
      cls_nxt = CLS_EXT;
    end else begin
      cls_nxt = CLS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      bcast_addr_r <= RST_BCAST_ADDR;
      local_bit_r  <= RST_LOCAL_BIT;
      text_svc_r   <= RST_TEXT_SVC;
      cmd_svc_r    <= RST_CMD_SVC;
      alive_svc_r  <= RST_ALIVE_SVC;
      show_hb_r    <= RST_SHOW_HB;
      start_r      <= 1'b0;
      hit_r        <= 1'b0;
      wp_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      start_r     <= in_acc & (in_action == ACT_CHECK);
      out_valid_r <= finish | (out_valid_r & ~out_ready);
      if (cfg_valid) begin
        case (cfg_index)
          CFG_BCAST_ADDR: bcast_addr_r <= cfg_data;
          CFG_LOCAL_BIT:  local_bit_r  <= cfg_data[2:0];
          CFG_TEXT_SVC:   text_svc_r   <= cfg_data[7:0];
          CFG_CMD_SVC:    cmd_svc_r    <= cfg_data[7:0];
          CFG_ALIVE_SVC:  alive_svc_r  <= cfg_data[7:0];
          CFG_SHOW_HB:    show_hb_r    <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            hit_r <= 1'b0;
            if (in_action == ACT_RECORD) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (link[ID_DEPTH].tok) begin
            hit_r   <= link[ID_DEPTH].hit;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            state_r <= S_IDLE;
            if (store_en) begin
              wp_r <= wp_nxt;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      action_r <= in_action;
      key_r    <= in_packet_id;
      dest_r   <= in_dest_address;
      flags_r  <= in_packet_flags;
      svc_r    <= in_packet_service;
    end
    if (finish) begin
      if (action_r == ACT_RECORD || hit_r) begin
        dup_r  <= (action_r == ACT_CHECK);
        fwd_r  <= 1'b0;
        kind_r <= CAST_DIRECT;
        cls_r  <= CLS_NONE;
      end else begin
        dup_r  <= 1'b0;
        fwd_r  <= fwd_nxt;
        kind_r <= kind_nxt;
        cls_r  <= cls_nxt;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_duplicate      = dup_r;
  assign out_forward        = fwd_r;
  assign out_cast_kind      = kind_r;
  assign out_handling_class = cls_r;

endmodule

@@ rtl/mdf_checker.sv @@
// Port-level assertions for the mesh duplicate filter, bound to the top level.
module mdf_checker
  import mdf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_duplicate,
  input logic       out_forward,
  input logic [1:0] out_cast_kind,
  input logic [2:0] out_handling_class
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_duplicate) &&
      $stable(out_forward) && $stable(out_cast_kind) && $stable(out_handling_class))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

  a_dup_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_duplicate |-> !out_forward && out_cast_kind == CAST_DIRECT &&
      out_handling_class == CLS_NONE)
    else $error("duplicate with classification");

  a_fwd_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_forward |-> out_cast_kind == CAST_BCAST)
    else $error("forward without plain broadcast");

endmodule

bind mesh_duplicate_filter mdf_checker u_mdf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_duplicate      (out_duplicate),
  .out_forward        (out_forward),
  .out_cast_kind      (out_cast_kind),
  .out_handling_class (out_handling_class)
);

@@ tb/mesh_duplicate_filter_checker.sv @@
// Result checker for the mesh duplicate filter: mirrors the ID ring and settings, predicts each result and compares.
module mesh_duplicate_filter_checker
  import mdf_pkg::*;
#(
  parameter int ID_DEPTH = DEF_ID_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_action,
  input  logic [31:0] in_packet_id,
  input  logic [31:0] in_dest_address,
  input  logic [7:0]  in_packet_flags,
  input  logic [7:0]  in_packet_service,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_duplicate,
  input  logic        out_forward,
  input  logic [1:0]  out_cast_kind,
  input  logic [2:0]  out_handling_class,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fault_count,
  output int          verdicts_owed
);

  typedef struct packed {
    logic       duplicate;
    logic       forward;
    logic [1:0] cast_kind;
    logic [2:0] handling_class;
  } verdict_t;

  logic [31:0] bcast_addr;
  logic [2:0]  local_bit;
  logic [7:0]  text_svc;
  logic [7:0]  cmd_svc;
  logic [7:0]  alive_svc;
  logic        show_hb;
  logic [31:0] id_ring [ID_DEPTH];
  int          ring_ptr;
  verdict_t    owed_verdicts [$];
  int          faults = 0;

  // pointer moves first, so the first stored ID lands in entry one
  function automatic void remember_id(input logic [31:0] id);
    ring_ptr = (ring_ptr + 1 == ID_DEPTH) ? 0 : ring_ptr + 1;
    id_ring[ring_ptr] = id;
  endfunction

  function automatic verdict_t filter_packet(input logic act, input logic [31:0] id,
                                             input logic [31:0] dest, input logic [7:0] flags,
                                             input logic [7:0] svc);
    verdict_t v;
    logic     seen;
    logic     bcast;
    logic     nbr_only;
    v = '0;
    seen = 1'b0;
    if (act == ACT_RECORD) begin
      remember_id(id);
      return v;
    end
    foreach (id_ring[i])
      if (id_ring[i] == id) seen = 1'b1;
    if (seen) begin
      v.duplicate = 1'b1;
      return v;
    end
    remember_id(id);
    bcast = (dest == bcast_addr);
    nbr_only = flags[local_bit];
    v.forward = bcast && !nbr_only;
    v.cast_kind = !bcast ? CAST_DIRECT : (nbr_only ? CAST_LOCAL : CAST_BCAST);
    if (svc == text_svc) v.handling_class = CLS_TEXT;
    else if (svc == cmd_svc) v.handling_class = CLS_CMD;
    else if (svc == alive_svc && show_hb) v.handling_class = CLS_ALIVE;
    else if (svc > EXT_SERVICE_FLOOR) v.handling_class = CLS_EXT;
    else v.handling_class = CLS_NONE;
    return v;
  endfunction

  task automatic log_fault(input string what, input verdict_t want, input verdict_t got);
    faults++;
    if (faults <= 10)
      $display("%0t: %s: expected dup=%0b fwd=%0b kind=%0d cls=%0d, got dup=%0b fwd=%0b kind=%0d cls=%0d",
               $realtime, what, want.duplicate, want.forward, want.cast_kind, want.handling_class,
               got.duplicate, got.forward, got.cast_kind, got.handling_class);
  endtask

  always @(posedge clk) begin : watch
    verdict_t got;
    verdict_t want;
    if (!rst_n) begin
      bcast_addr = RST_BCAST_ADDR;
      local_bit = RST_LOCAL_BIT;
      text_svc = RST_TEXT_SVC;
      cmd_svc = RST_CMD_SVC;
      alive_svc = RST_ALIVE_SVC;
      show_hb = RST_SHOW_HB;
      foreach (id_ring[i]) id_ring[i] = '0;
      ring_ptr = 0;
      owed_verdicts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BCAST_ADDR: bcast_addr = cfg_data;
          CFG_LOCAL_BIT:  local_bit = cfg_data[2:0];
          CFG_TEXT_SVC:   text_svc = cfg_data[7:0];
          CFG_CMD_SVC:    cmd_svc = cfg_data[7:0];
          CFG_ALIVE_SVC:  alive_svc = cfg_data[7:0];
          CFG_SHOW_HB:    show_hb = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = {out_duplicate, out_forward, out_cast_kind, out_handling_class};
        if (owed_verdicts.size() == 0) begin
          log_fault("result with nothing outstanding", '0, got);
        end else begin
          want = owed_verdicts.pop_front();
          if (got !== want) log_fault("result mismatch", want, got);
        end
      end
      if (in_valid && in_ready)
        owed_verdicts.push_back(filter_packet(in_action, in_packet_id, in_dest_address,
                                              in_packet_flags, in_packet_service));
    end
    fault_count <= faults;
    verdicts_owed <= owed_verdicts.size();
  end

endmodule

@@ tb/mesh_duplicate_filter_test.sv @@
// Testbench top for the mesh duplicate filter: clock, reset, packet and register stimulus, verdict.
module mesh_duplicate_filter_test;
  import mdf_pkg::*;

  localparam int LIMIT = 400_000;
  localparam int PHASE_ITEMS = 90;
  localparam logic [2:0] CFG_UNUSED = 3'd6;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_action;
  logic [31:0] in_packet_id;
  logic [31:0] in_dest_address;
  logic [7:0]  in_packet_flags;
  logic [7:0]  in_packet_service;
  logic        out_valid;
  logic        out_ready;
  logic        out_duplicate;
  logic        out_forward;
  logic [1:0]  out_cast_kind;
  logic [2:0]  out_handling_class;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fault_count;
  int          verdicts_owed;

  logic [31:0] cur_bcast = RST_BCAST_ADDR;
  logic [7:0]  cur_text = RST_TEXT_SVC;
  logic [7:0]  cur_cmd = RST_CMD_SVC;
  logic [7:0]  cur_alive = RST_ALIVE_SVC;
  logic [31:0] id_history [$];
  bit          eager = 1'b0;
  int          cycles = 0;

  always #2 clk = ~clk;

  mesh_duplicate_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_packet_id(in_packet_id), .in_dest_address(in_dest_address),
    .in_packet_flags(in_packet_flags), .in_packet_service(in_packet_service),
    .out_valid(out_valid), .out_ready(out_ready), .out_duplicate(out_duplicate),
    .out_forward(out_forward), .out_cast_kind(out_cast_kind),
    .out_handling_class(out_handling_class),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mesh_duplicate_filter_checker verdict_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_packet_id(in_packet_id), .in_dest_address(in_dest_address),
    .in_packet_flags(in_packet_flags), .in_packet_service(in_packet_service),
    .out_valid(out_valid), .out_ready(out_ready), .out_duplicate(out_duplicate),
    .out_forward(out_forward), .out_cast_kind(out_cast_kind),
    .out_handling_class(out_handling_class),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fault_count(fault_count), .verdicts_owed(verdicts_owed)
  );

  task automatic offer_packet(input logic act, input logic [31:0] id, input logic [31:0] dest,
                              input logic [7:0] flags, input logic [7:0] svc);
    int gap;
    in_valid <= 1'b1;
    in_action <= act;
    in_packet_id <= id;
    in_dest_address <= dest;
    in_packet_flags <= flags;
    in_packet_service <= svc;
    do @(posedge clk); while (!in_ready);
    if (eager || $urandom_range(0, 9) < 6) gap = 0;
    else if ($urandom_range(0, 7) != 0) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 50);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic offer_random_packet();
    logic        act;
    logic [31:0] id;
    logic [31:0] dest;
    logic [7:0]  svc;
    int          pick;
    act = ($urandom_range(0, 4) == 0) ? ACT_RECORD : ACT_CHECK;
    pick = $urandom_range(0, 19);
    if (pick < 9 && id_history.size() > 0)
      id = id_history[$urandom_range(0, id_history.size() - 1)];
    else if (pick == 9) id = 32'h0;
    else if (pick == 10) id = 32'hFFFF_FFFF;
    else id = $urandom;
    id_history.push_back(id);
    if (id_history.size() > 48) void'(id_history.pop_front());
    pick = $urandom_range(0, 9);
    if (pick < 5) dest = cur_bcast;
    else if (pick == 5) dest = cur_bcast ^ (32'h1 << $urandom_range(0, 31));
    else dest = $urandom;
    case ($urandom_range(0, 7))
      0: svc = cur_text;
      1: svc = cur_cmd;
      2: svc = cur_alive;
      3: svc = EXT_SERVICE_FLOOR;
      4: svc = EXT_SERVICE_FLOOR + 8'd1;
      5: svc = 8'($urandom_range(0, 16));
      default: svc = 8'($urandom);
    endcase
    offer_packet(act, id, dest, 8'($urandom), svc);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // upper data bits are random: narrow registers must ignore them
  task automatic program_filter(input logic [31:0] bcast, input logic [2:0] lbit,
                                input logic [7:0] text, input logic [7:0] cmd,
                                input logic [7:0] alive, input logic show);
    write_reg(CFG_BCAST_ADDR, bcast);
    write_reg(CFG_LOCAL_BIT, ($urandom << 3) | lbit);
    write_reg(CFG_TEXT_SVC, ($urandom << 8) | text);
    write_reg(CFG_CMD_SVC, ($urandom << 8) | cmd);
    write_reg(CFG_ALIVE_SVC, ($urandom << 8) | alive);
    write_reg(CFG_SHOW_HB, ($urandom << 1) | show);
    write_reg(CFG_UNUSED + 3'($urandom_range(0, 1)), $urandom);
    cfg_valid <= 1'b0;
    cur_bcast = bcast;
    cur_text = text;
    cur_cmd = cmd;
    cur_alive = alive;
  endtask

  task automatic await_drain();
    do @(posedge clk); while (verdicts_owed != 0);
  endtask

  // receiver: random back-pressure plus one long hold to fill the block
  initial begin
    int stall;
    int taken;
    bit squeezed;
    stall = 0;
    taken = 0;
    squeezed = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!squeezed && taken >= 120) begin
        squeezed = 1'b1;
        stall = 499;
        out_ready <= 1'b0;
      end else if (taken % 64 < 16 || $urandom_range(0, 9) < 7) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= ACT_CHECK;
    in_packet_id <= '0;
    in_dest_address <= '0;
    in_packet_flags <= '0;
    in_packet_service <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BCAST_ADDR;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings; zero ID hits the cleared ring
    offer_packet(ACT_CHECK,  32'h0000_0000, 32'hFFFF_FFFF, 8'h00, 8'd0);
    offer_packet(ACT_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 8'd0);
    offer_packet(ACT_CHECK,  32'hFFFF_FFFF, 32'h0000_0000, 8'hFF, 8'd255);
    offer_packet(ACT_RECORD, 32'h1234_5678, 32'h0000_0000, 8'h00, 8'd0);
    offer_packet(ACT_CHECK,  32'h1234_5678, 32'hFFFF_FFFF, 8'h00, 8'd1);
    offer_packet(ACT_RECORD, 32'h1234_5678, 32'hFFFF_FFFF, 8'hFF, 8'd255);
    offer_packet(ACT_CHECK,  32'h0000_0001, 32'hFFFF_FFFF, 8'h80, 8'd1);
    offer_packet(ACT_CHECK,  32'h0000_0002, 32'hFFFF_FFFF, 8'h7F, 8'd2);
    offer_packet(ACT_CHECK,  32'h0000_0003, 32'h0000_0000, 8'hFF, 8'd16);
    offer_packet(ACT_CHECK,  32'h0000_0004, 32'hFFFF_FFFE, 8'h00, 8'd17);
    offer_packet(ACT_CHECK,  32'h8000_0000, 32'hFFFF_FFFF, 8'h00, 8'd255);
    offer_packet(ACT_CHECK,  32'h0000_0005, 32'h7FFF_FFFF, 8'hAA, 8'd3);
    offer_packet(ACT_RECORD, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 8'd0);
    offer_packet(ACT_RECORD, 32'h0000_0000, 32'h0000_0000, 8'h00, 8'd0);
    offer_packet(ACT_CHECK,  32'h0000_0000, 32'hFFFF_FFFF, 8'h00, 8'd2);
    offer_packet(ACT_CHECK,  32'h5A5A_A5A5, 32'hFFFF_FFFF, 8'h55, 8'd128);
    in_valid <= 1'b0;
    await_drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: program_filter(32'h0000_0000, 3'd0, 8'd255, 8'd17, 8'd16, 1'b0);
        1: program_filter($urandom, 3'd3, 8'd5, 8'd5, 8'd5, 1'b1);
        2: program_filter(32'hFFFF_FFFF, 3'd7, 8'd0, 8'd1, 8'd2, 1'b0);
        3: program_filter($urandom, 3'($urandom), 8'($urandom_range(0, 20)),
                          8'($urandom_range(0, 20)), 8'($urandom_range(0, 20)),
                          1'($urandom));
        default: program_filter(32'hFFFF_FFFF, 3'd7, 8'd0, 8'd200, 8'd200, 1'b1);
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        eager = (i % 45) < 12;
        offer_random_packet();
      end
      eager = 1'b0;
      in_valid <= 1'b0;
      await_drain();
    end

    repeat (DEF_ID_DEPTH + 8) @(posedge clk);
    if (fault_count == 0 && verdicts_owed == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mdf_pkg.sv
rtl/mdf_cell.sv
rtl/mesh_duplicate_filter.sv
rtl/mdf_checker.sv
tb/mesh_duplicate_filter_checker.sv
tb/mesh_duplicate_filter_test.sv
